[rtl/kst_pkg.sv]
// shared widths, opcodes and defaults for the key state tracker
`timescale 1ns / 1ps
package kst_pkg;

  localparam int OPCODE_W    = 2;
  localparam int KEY_CODE_W  = 8;
  localparam int KEY_STATE_W = 2;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KEY_COUNT_DEF   = 256;

  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [KEY_CODE_W-1:0]  key_code_t;
  typedef logic [KEY_STATE_W-1:0] key_state_t;

  localparam opcode_t OP_KEY_EVENT = 2'd0;
  localparam opcode_t OP_TICK      = 2'd1;
  localparam opcode_t OP_QUERY     = 2'd2;
  localparam opcode_t OP_CLEAR     = 2'd3;

endpackage

[rtl/kst_req_if.sv]
// request channel interface: opcode, key code and key direction
`timescale 1ns / 1ps
interface kst_req_if;
  import kst_pkg::*;

  logic      valid;
  logic      ready;
  opcode_t   opcode;
  key_code_t key_code;
  logic      key_pressed;

  modport source (output valid, output opcode, output key_code, output key_pressed,
                  input ready);
  modport sink (input valid, input opcode, input key_code, input key_pressed,
                output ready);
endinterface

[rtl/kst_rsp_if.sv]
// response channel interface: key state and event acceptance flag
`timescale 1ns / 1ps
interface kst_rsp_if;
  import kst_pkg::*;

  logic       valid;
  logic       ready;
  key_state_t key_state;
  logic       accepted;

  modport source (output valid, output key_state, output accepted, input ready);
  modport sink (input valid, input key_state, input accepted, output ready);
endinterface

[rtl/key_state_tracker.sv]
// key state tracker top level: per-key current/previous/pending bits and event count
//
// usage:
//   req carries one transaction per item: opcode (key event, tick, query,
//   clear), key_code and key_pressed. rsp returns exactly one transaction per
//   item: key_state (query answer, else 0) and accepted (key event taken).
//   cfg_we/cfg_wdata write keyboard_enabled; write it only while idle.
// an item taken from req is held in the input register, processed against
//   the key state, and shows on rsp from the result register.
// throughput: one transaction per cycle while rsp is not held; every opcode
//   touches one key bit or all key bits in parallel, combinationally between
//   the input register and the result register.
// reset: all key bits, the event count and keyboard_enabled clear; both
//   channels go idle. no clearing pass is needed.
// stall: while rsp is held, the result register keeps its transaction and
//   the input register keeps one more; req.ready drops only when both are
//   full, and no transaction is lost or repeated.
`timescale 1ns / 1ps
module key_state_tracker #(
  parameter int QUEUE_DEPTH = kst_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = kst_pkg::KEY_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  kst_req_if.sink        req,
  kst_rsp_if.source      rsp
);
  import kst_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(KEY_COUNT);

  logic                 keyboard_enabled;
  logic [KEY_COUNT-1:0] current_bits;
  logic [KEY_COUNT-1:0] previous_bits;
  logic [KEY_COUNT-1:0] pending_bits;
  logic [CNT_W-1:0]     event_count;

  logic [KEY_COUNT-1:0] current_next;
  logic [KEY_COUNT-1:0] previous_next;
  logic [KEY_COUNT-1:0] pending_next;
  logic [CNT_W-1:0]     event_count_next;
  key_state_t           key_state_next;
  logic                 accepted_next;

  logic      item_valid;
  opcode_t   item_opcode;
  key_code_t item_code;
  logic      item_down;

  logic             advance;
  logic             in_range;
  logic             event_ok;
  logic [IDX_W-1:0] key_idx;

  assign advance   = item_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !item_valid || advance;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      keyboard_enabled <= 1'b0;
    end else if (cfg_we) begin
      keyboard_enabled <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_opcode <= req.opcode;
      item_code   <= req.key_code;
      item_down   <= req.key_pressed;
    end
  end

  assign in_range = {1'b0, item_code} < (KEY_CODE_W + 1)'(KEY_COUNT);
  assign key_idx  = item_code[IDX_W-1:0];
  assign event_ok = keyboard_enabled && (event_count < CNT_W'(QUEUE_DEPTH)) &&
                    (item_code != '0) && in_range;

  always_comb begin
    current_next     = current_bits;
    previous_next    = previous_bits;
    pending_next     = pending_bits;
    event_count_next = event_count;
    key_state_next   = '0;
    accepted_next    = 1'b0;
    unique case (item_opcode)
      OP_KEY_EVENT: begin
        if (event_ok) begin
          pending_next[key_idx] = item_down;
          event_count_next      = event_count + CNT_W'(1);
          accepted_next         = 1'b1;
        end
      end
      OP_TICK: begin
        previous_next    = current_bits;
        current_next     = pending_bits;
        event_count_next = '0;
      end
      OP_QUERY: begin
        if (in_range) begin
          key_state_next = {previous_bits[key_idx], current_bits[key_idx]};
        end
      end
      OP_CLEAR: begin
        current_next     = '0;
        previous_next    = '0;
        pending_next     = '0;
        event_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // key state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_bits  <= '0;
      previous_bits <= '0;
      pending_bits  <= '0;
      event_count   <= '0;
    end else if (advance) begin
      current_bits  <= current_next;
      previous_bits <= previous_next;
      pending_bits  <= pending_next;
      event_count   <= event_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.key_state <= key_state_next;
      rsp.accepted  <= accepted_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CNT_W'(QUEUE_DEPTH))
    else $error("event count above queue depth");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.accepted |-> rsp.key_state == '0)
    else $error("accepted event carries a key state");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    advance && item_opcode == OP_CLEAR |=>
      current_bits == '0 && previous_bits == '0 && pending_bits == '0 &&
      event_count == '0)
    else $error("clear left key state behind");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> item_valid && rsp.valid && !rsp.ready)
    else $error("request stalled without a held result");
`endif

endmodule
